/* rtl/ptts_pkg.sv */
// shared types and constants of the periodic task tick scheduler
// no dependencies; used by the channel interfaces and the top level
package ptts_pkg;

  localparam int TASK_COUNT_DEF = 8;
  localparam int CNT_W          = 16;
  localparam int MODE_W         = 3;
  localparam int INDEX_W        = 3;
  localparam int MASK_W         = 8;
  localparam int STATUS_W       = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_SUSPEND = 3'd2,
    MODE_RESUME  = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_USED       = 2'd1,
    STATUS_NO_HANDLER = 2'd2
  } status_t;

endpackage

/* rtl/ptts_in_if.sv */
// request channel of the scheduler: valid/ready plus one command beat
// depends on ptts_pkg for field widths
interface ptts_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptts_pkg::MODE_W-1:0]   mode;
  logic [ptts_pkg::INDEX_W-1:0]  task_index;
  logic [ptts_pkg::CNT_W-1:0]    period;
  logic [ptts_pkg::CNT_W-1:0]    first_delay;
  logic                          has_handler;

  modport source (output valid, mode, task_index, period, first_delay, has_handler,
                  input ready);
  modport sink   (input valid, mode, task_index, period, first_delay, has_handler,
                  output ready);
endinterface

/* rtl/ptts_out_if.sv */
// result channel of the scheduler: valid/ready plus fired mask and status
// depends on ptts_pkg for field widths
interface ptts_out_if;
  logic                           valid;
  logic                           ready;
  logic [ptts_pkg::MASK_W-1:0]    fired_mask;
  logic [ptts_pkg::STATUS_W-1:0]  status;

  modport source (output valid, fired_mask, status, input ready);
  modport sink   (input valid, fired_mask, status, output ready);
endinterface

/* rtl/ptts_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module ptts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/periodic_task_tick_scheduler.sv */
// top level of the periodic task tick scheduler: slot table, tick sequencer, result register
// depends on ptts_pkg, ptts_in_if, ptts_out_if and ptts_ram
//
// Each beat on in_chan is one command and gives exactly one beat on out_chan. Create,
// suspend, resume and delete finish in the cycle they are accepted; the result is
// registered at that edge. A tick walks the slot table one slot per cycle through a single
// read port of the countdown/period ram and one shared 16-bit decrementer, so it holds
// in_chan.ready low for the whole walk and registers its result in the walk's last cycle. The ram
// resets logically through one valid bit per slot: a slot never written reads as zero.
// A new command is taken while the previous result is still held, as long as that result
// is taken in the same cycle or the output register is empty.
module periodic_task_tick_scheduler #(
  parameter int TASK_COUNT = ptts_pkg::TASK_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ptts_in_if.sink    in_chan,
  ptts_out_if.source out_chan
);

  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CW = $clog2(TASK_COUNT + 1);
  localparam int DW = ptts_pkg::CNT_W;
  localparam logic [CW-1:0]   N_CNT = CW'(TASK_COUNT);
  localparam logic [CW+2:0]   N_EXT = (CW + 3)'(TASK_COUNT);
  localparam logic [IW+2:0]   MASK_SLOTS = (IW + 3)'(ptts_pkg::MASK_W);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TICK = 2'b10
  } state_t;

  state_t                         state_r;
  logic [CW-1:0]                  cnt_r;
  logic                           proc_r;
  logic [IW-1:0]                  slot_r;
  logic [ptts_pkg::MASK_W-1:0]    mask_r;
  logic [TASK_COUNT-1:0]          vld_r;
  logic [TASK_COUNT-1:0]          active_r;
  logic [TASK_COUNT-1:0]          present_r;
  logic                           out_valid_r;
  logic [ptts_pkg::MASK_W-1:0]    out_mask_r;
  ptts_pkg::status_t              out_status_r;

  logic                           in_fire;
  logic                           out_free;
  logic                           res_load;
  ptts_pkg::mode_t                mode;
  logic [CW+2:0]                  idx_ext;
  logic [IW+2:0]                  idx_wide;
  logic [IW-1:0]                  idx;
  logic                           idx_ok;
  ptts_pkg::status_t              create_status;
  logic                           create_ok;

  logic                           rd_en;
  logic [IW-1:0]                  ram_raddr;
  logic [2*DW-1:0]                ram_rdata;
  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  logic [2*DW-1:0]                ram_wdata;

  logic [DW-1:0]                  cd_q;
  logic [DW-1:0]                  rl_q;
  logic                           cd_zero;
  logic [DW-1:0]                  dec_in;
  logic [DW-1:0]                  dec_out;
  logic [IW+2:0]                  slot_ext;
  logic                           fire_bit;
  logic [ptts_pkg::MASK_W-1:0]    mask_nxt;

  // handshake
  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.fired_mask = out_mask_r;
  assign out_chan.status     = out_status_r;

  // command decode
  assign mode     = ptts_pkg::mode_t'(in_chan.mode);
  assign idx_ext  = {{CW{1'b0}}, in_chan.task_index};
  assign idx_ok   = idx_ext < N_EXT;
  assign idx_wide = {{IW{1'b0}}, in_chan.task_index};
  assign idx      = idx_wide[IW-1:0];

  always_comb begin
    create_status = ptts_pkg::STATUS_OK;
    create_ok     = 1'b0;
    if (mode == ptts_pkg::MODE_CREATE && idx_ok) begin
      priority if (!in_chan.has_handler) begin
        create_status = ptts_pkg::STATUS_NO_HANDLER;
      end else if (present_r[idx]) begin
        create_status = ptts_pkg::STATUS_USED;
      end else begin
        create_ok = 1'b1;
      end
    end
  end

  // tick walk: read slot cnt_r, update slot_r in the next cycle with the read data
  assign rd_en     = (state_r == ST_TICK) && (cnt_r < N_CNT);
  assign ram_raddr = cnt_r[IW-1:0];

  assign cd_q    = vld_r[slot_r] ? ram_rdata[DW-1:0]    : '0;
  assign rl_q    = vld_r[slot_r] ? ram_rdata[2*DW-1:DW] : '0;
  assign cd_zero = (cd_q == '0);

  // shared decrementer: reload minus one on expiry, else countdown minus one
  assign dec_in  = cd_zero ? rl_q : cd_q;
  assign dec_out = dec_in - DW'(1);

  assign slot_ext = {3'b000, slot_r};
  assign fire_bit = cd_zero && active_r[slot_r] && present_r[slot_r] && (slot_ext < MASK_SLOTS);
  assign mask_nxt = mask_r | (fire_bit ? (ptts_pkg::MASK_W'(1) << slot_ext[2:0])
                                       : ptts_pkg::MASK_W'(0));

  // a result is loaded by a non-tick command or by the last cycle of a tick walk
  assign res_load = (in_fire && mode != ptts_pkg::MODE_TICK) ||
                    (state_r == ST_TICK && !rd_en);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = {rl_q, dec_out};
    if (state_r == ST_TICK && proc_r) begin
      ram_we = 1'b1;
    end else if (in_fire && create_ok) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = {in_chan.period, in_chan.first_delay};
    end
  end

  ptts_ram #(
    .WIDTH (2 * DW),
    .DEPTH (TASK_COUNT),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // an entry counts as zero until its first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      proc_r      <= 1'b0;
      active_r    <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      priority if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (mode == ptts_pkg::MODE_TICK) begin
              state_r <= ST_TICK;
              cnt_r   <= '0;
              proc_r  <= 1'b0;
              mask_r  <= '0;
            end else begin
              out_mask_r   <= '0;
              out_status_r <= create_status;
              if (idx_ok) begin
                unique case (mode)
                  ptts_pkg::MODE_CREATE: begin
                    if (create_ok) begin
                      active_r[idx]  <= 1'b1;
                      present_r[idx] <= 1'b1;
                    end
                  end
                  ptts_pkg::MODE_SUSPEND: active_r[idx]  <= 1'b0;
                  ptts_pkg::MODE_RESUME:  active_r[idx]  <= 1'b1;
                  ptts_pkg::MODE_DELETE:  present_r[idx] <= 1'b0;
                  default: ;
                endcase
              end
            end
          end
        end
        ST_TICK: begin
          proc_r <= rd_en;
          slot_r <= ram_raddr;
          if (rd_en) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (proc_r) begin
            mask_r <= mask_nxt;
          end
          if (!rd_en) begin
            // last slot written back this cycle
            state_r      <= ST_IDLE;
            out_mask_r   <= mask_nxt;
            out_status_r <= ptts_pkg::STATUS_OK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no result may be pending while the table is being walked
  a_no_result_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TICK |-> !out_valid_r)
    else $error("result register busy during tick walk");

  // a command other than tick answers on the next cycle
  a_cmd_answers: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode != ptts_pkg::MODE_TICK |=> out_valid_r && state_r == ST_IDLE)
    else $error("command beat gave no result");

  // an error status never comes with fired tasks
  a_status_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ptts_pkg::STATUS_OK |-> out_mask_r == '0)
    else $error("error status with fired mask");

  // the write-back never hits the slot being read
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && proc_r |-> ram_waddr != ram_raddr)
    else $error("tick write-back collides with read");

  // a tick starts its walk at slot zero with nothing pending
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode == ptts_pkg::MODE_TICK |=> state_r == ST_TICK && cnt_r == '0 && !proc_r)
    else $error("tick walk did not start cleanly");
`endif

endmodule
